@@ sv/pig_pkg.sv @@
// Shared types and constants for the pose integrator with grid revert.
package pig_pkg;

	localparam int OCC_LIMIT = 50;
	localparam int ATAN_ENTRIES = 24;
	localparam logic [15:0] GAIN_INV_Q16 = 16'd39797;

	typedef enum logic [2:0] {
		REG_GRID_WIDTH = 3'd0,
		REG_GRID_HEIGHT = 3'd1,
		REG_ORIGIN_X = 3'd2,
		REG_ORIGIN_Y = 3'd3,
		REG_CELLS_PER_METER = 3'd4
	} reg_index_t;

	typedef enum logic {
		OP_MAP_WRITE = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [0:0] opcode;
		logic [15:0] cell_index;
		logic signed [7:0] cell_value;
		logic signed [15:0] vel_forward;
		logic signed [15:0] vel_lateral;
		logic signed [15:0] turn_rate;
		logic [15:0] time_step;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [15:0] heading;
		logic [0:0] blocked;
	} out_item_t;

	typedef struct packed {
		logic [2:0] index;
		logic [31:0] data;
	} cfg_item_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic [31:0] atan_turn32(input logic [4:0] i);
		logic [31:0] r;
		begin
			case (i)
				5'd0: r = 32'd536870912;
				5'd1: r = 32'd316933406;
				5'd2: r = 32'd167458907;
				5'd3: r = 32'd85004756;
				5'd4: r = 32'd42667331;
				5'd5: r = 32'd21354465;
				5'd6: r = 32'd10679838;
				5'd7: r = 32'd5340245;
				5'd8: r = 32'd2670163;
				5'd9: r = 32'd1335087;
				5'd10: r = 32'd667544;
				5'd11: r = 32'd333772;
				5'd12: r = 32'd166886;
				5'd13: r = 32'd83443;
				5'd14: r = 32'd41722;
				5'd15: r = 32'd20861;
				5'd16: r = 32'd10430;
				5'd17: r = 32'd5215;
				5'd18: r = 32'd2608;
				5'd19: r = 32'd1304;
				5'd20: r = 32'd652;
				5'd21: r = 32'd326;
				5'd22: r = 32'd163;
				5'd23: r = 32'd81;
				default: r = 32'd0;
			endcase
			return r;
		end
	endfunction

endpackage

@@ sv/pig_stream_if.sv @@
// Valid/ready channel interface carrying one payload of a given type.
interface pig_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ sv/pig_ram.sv @@
// Generic single-port RAM with registered read.
module pig_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ sv/pig_serial_mul.sv @@
// Shift-and-add signed by unsigned multiplier, one multiplier bit per cycle.
module pig_serial_mul #(
	parameter int AW = 48,
	parameter int BW = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [AW-1:0] a,
	input logic [BW-1:0] b,
	output logic done,
	output logic signed [AW+BW-1:0] product
);
	localparam int CW = $clog2(BW + 1);

	logic signed [AW+BW-1:0] acc_q;
	logic signed [AW+BW-1:0] mcand_q;
	logic [BW-1:0] mplier_q;
	logic [CW-1:0] count_q;
	logic busy_q;

	assign product = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			count_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				count_q <= '0;
			end else if (busy_q) begin
				count_q <= count_q + 1'b1;
				if (count_q == CW'(BW - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mcand_q <= (AW+BW)'(a);
			mplier_q <= b;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end
endmodule

@@ sv/pig_cordic.sv @@
// Iterative CORDIC rotation of the body velocity by the heading.
module pig_cordic #(
	parameter int CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [15:0] vx,
	input logic signed [15:0] vy,
	input logic [15:0] angle,
	output logic done,
	output logic signed [47:0] x_out,
	output logic signed [47:0] y_out
);
	import pig_pkg::*;

	localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

	logic signed [47:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [4:0] i_q;
	logic busy_q;
	logic signed [15:0] a;
	logic flip;
	logic signed [47:0] xs, ys;

	assign a = signed'(angle);
	assign flip = (a > 16'sd16384) || (a < -16'sd16384);
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign x_out = x_q;
	assign y_out = y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == 5'(NSTEPS - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (flip) begin
				x_q <= -(48'(vx) <<< 16);
				y_q <= -(48'(vy) <<< 16);
				z_q <= (34'(a) <<< 16) + (a > 16'sd0 ? -34'sd2147483648 : 34'sd2147483648);
			end else begin
				x_q <= 48'(vx) <<< 16;
				y_q <= 48'(vy) <<< 16;
				z_q <= 34'(a) <<< 16;
			end
		end else if (busy_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - signed'({2'b00, atan_turn32(i_q)});
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + signed'({2'b00, atan_turn32(i_q)});
			end
		end
	end
endmodule

@@ sv/pose_integrator_grid_revert.sv @@
// Top level of the dead-reckoning pose integrator with occupancy-grid revert.
//
// Channel   Role      Payload
// in_ch     sink      opcode, cell_index, cell_value, velocities, turn_rate, time_step
// out_ch    source    pos_x, pos_y, heading, blocked
// cfg_ch    sink      register index and write data
//
// A map write goes from ST_MAPW to ST_OUT. A tick runs the iterative CORDIC, then the
// bit-serial 16-bit multiplier for the gain, the x, y and heading steps and, with a map
// (nonzero grid height), the column and row, then the index, grid read and occupancy check.
// One item is in flight at a time; the result register waits for out_ch.ready.
// Reset clears pose and registers (cpm_q to 256); grid memory is undefined until written.
module pose_integrator_grid_revert #(
	parameter int MAP_CELLS = 65536,
	parameter int CORDIC_STEPS = 16
) (
	input logic clk,
	input logic arst_n,
	pig_stream_if.sink in_ch,
	pig_stream_if.source out_ch,
	pig_stream_if.sink cfg_ch
);
	import pig_pkg::*;

	localparam int AW = $clog2(MAP_CELLS);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MAPW, ST_CORDIC, ST_GAINX, ST_GAINY, ST_DTX, ST_DTY, ST_DTH,
		ST_COLX, ST_ROWY, ST_IDX, ST_READ, ST_CHECK, ST_OUT
	} state_t;

	state_t state_q;
	in_item_t item_q;
	logic [15:0] grid_width_q, grid_height_q, cpm_q;
	logic signed [31:0] origin_x_q, origin_y_q;
	logic [31:0] px_q, py_q, old_x_q, old_y_q;
	logic [15:0] h_q, old_h_q;
	logic signed [47:0] vx_q, vy_q;
	logic signed [63:0] col_q, row_q;
	logic [63:0] idx_q;
	logic blocked_q;
	logic mul_wait_q;

	logic cordic_start, cordic_done;
	logic signed [47:0] cx, cy;
	logic mul_start, mul_done;
	logic signed [47:0] mul_a;
	logic [15:0] mul_b;
	logic signed [63:0] mul_p;

	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [7:0] ram_rdata;

	pig_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cordic_start),
		.vx(item_q.vel_forward), .vy(item_q.vel_lateral), .angle(h_q),
		.done(cordic_done), .x_out(cx), .y_out(cy)
	);

	pig_serial_mul #(.AW(48), .BW(16)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .product(mul_p)
	);

	pig_ram #(.WIDTH(8), .DEPTH(MAP_CELLS)) u_grid (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(item_q.cell_value),
		.rdata(ram_rdata)
	);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign cordic_start = (state_q == ST_CORDIC) && !mul_wait_q;
	assign mul_start = !mul_wait_q && (state_q == ST_GAINX || state_q == ST_GAINY ||
		state_q == ST_DTX || state_q == ST_DTY || state_q == ST_DTH ||
		state_q == ST_COLX || state_q == ST_ROWY);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_GAINX: begin mul_a = vx_q; mul_b = GAIN_INV_Q16; end
			ST_GAINY: begin mul_a = vy_q; mul_b = GAIN_INV_Q16; end
			ST_DTX: begin mul_a = vx_q; mul_b = item_q.time_step; end
			ST_DTY: begin mul_a = vy_q; mul_b = item_q.time_step; end
			ST_DTH: begin mul_a = 48'(item_q.turn_rate); mul_b = item_q.time_step; end
			ST_COLX: begin
				mul_a = 48'(signed'(px_q)) - 48'(origin_x_q);
				mul_b = cpm_q;
			end
			ST_ROWY: begin
				mul_a = 48'(signed'(py_q)) - 48'(origin_y_q);
				mul_b = cpm_q;
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_comb begin
		ram_we = (state_q == ST_MAPW) && (32'(item_q.cell_index) < MAP_CELLS);
		if (state_q == ST_MAPW) begin
			ram_addr = AW'(item_q.cell_index);
		end else begin
			ram_addr = idx_q[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			grid_width_q <= '0;
			grid_height_q <= '0;
			origin_x_q <= '0;
			origin_y_q <= '0;
			cpm_q <= 16'd256;
			px_q <= '0;
			py_q <= '0;
			h_q <= '0;
			blocked_q <= 1'b0;
			mul_wait_q <= 1'b0;
			out_ch.valid <= 1'b0;
			out_ch.payload <= '0;
		end else begin
			if (cfg_ch.valid) begin
				case (cfg_ch.payload.index)
					REG_GRID_WIDTH: grid_width_q <= cfg_ch.payload.data[15:0];
					REG_GRID_HEIGHT: grid_height_q <= cfg_ch.payload.data[15:0];
					REG_ORIGIN_X: origin_x_q <= signed'(cfg_ch.payload.data);
					REG_ORIGIN_Y: origin_y_q <= signed'(cfg_ch.payload.data);
					REG_CELLS_PER_METER: cpm_q <= cfg_ch.payload.data[15:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready && state_q != ST_OUT) begin
				out_ch.valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						item_q <= in_ch.payload;
						blocked_q <= 1'b0;
						mul_wait_q <= 1'b0;
						if (in_ch.payload.opcode == OP_TICK) begin
							old_x_q <= px_q;
							old_y_q <= py_q;
							old_h_q <= h_q;
							state_q <= ST_CORDIC;
						end else begin
							state_q <= ST_MAPW;
						end
					end
				end
				ST_MAPW: state_q <= ST_OUT;
				ST_CORDIC: begin
					mul_wait_q <= !cordic_done;
					if (cordic_done) begin
						vx_q <= cx;
						vy_q <= cy;
						state_q <= ST_GAINX;
					end
				end
				ST_GAINX, ST_GAINY, ST_DTX, ST_DTY, ST_DTH, ST_COLX, ST_ROWY: begin
					mul_wait_q <= !mul_done;
					if (mul_done) begin
						case (state_q)
							ST_GAINX: begin
								vx_q <= 48'(mul_p >>> 16);
								state_q <= ST_GAINY;
							end
							ST_GAINY: begin
								vy_q <= 48'(mul_p >>> 16);
								state_q <= ST_DTX;
							end
							ST_DTX: begin
								px_q <= px_q + 32'(mul_p >>> 24);
								state_q <= ST_DTY;
							end
							ST_DTY: begin
								py_q <= py_q + 32'(mul_p >>> 24);
								state_q <= ST_DTH;
							end
							ST_DTH: begin
								h_q <= h_q + 16'(mul_p >>> 16);
								state_q <= (grid_height_q != 16'd0) ? ST_COLX : ST_OUT;
							end
							ST_COLX: begin
								col_q <= mul_p >>> 24;
								state_q <= ST_ROWY;
							end
							default: begin
								row_q <= mul_p >>> 24;
								state_q <= ST_IDX;
							end
						endcase
					end
				end
				ST_IDX: begin
					if (col_q >= 0 && col_q < 64'(grid_width_q) &&
						row_q >= 0 && row_q < 64'(grid_height_q)) begin
						idx_q <= {32'b0, {16'b0, row_q[15:0]} * {16'b0, grid_width_q}} +
							{48'b0, col_q[15:0]};
						state_q <= ST_READ;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_READ: begin
					state_q <= (idx_q < 64'(MAP_CELLS)) ? ST_CHECK : ST_OUT;
				end
				ST_CHECK: begin
					if (signed'(ram_rdata) > 8'(OCC_LIMIT)) begin
						px_q <= old_x_q;
						py_q <= old_y_q;
						h_q <= old_h_q;
						blocked_q <= 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_ch.valid || out_ch.ready) begin
						out_ch.valid <= 1'b1;
						out_ch.payload <= '{pos_x: px_q, pos_y: py_q, heading: h_q,
							blocked: blocked_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ sv/pig_checker.sv @@
// Port-level assertions for the pose integrator, bound to the top level.
module pig_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [15:0] out_heading
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_heading))
		else $error("result dropped while stalled");
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while one is in flight");
	a_no_pass: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid || $past(out_valid))
		else $error("result appeared in the same cycle as acceptance");
	a_reset: assert property (@(posedge clk) !arst_n |=> !out_valid || arst_n)
		else $error("valid result during reset");
endmodule

bind pose_integrator_grid_revert pig_checker u_pig_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_heading(out_ch.payload.heading)
);
